/* rtl/fpba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fit-policy block allocator.
// Used by every module of the block but fpba_ram; depends on nothing.
package fpba_pkg;

  // Sizing of the block table.
  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Port widths fixed by the interface.
  localparam int PORT_IDX_BITS  = 4;
  localparam int PORT_SIZE_BITS = 16;
  localparam int PORT_CNT_BITS  = 5;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  // Reset value of the searched block count.
  localparam logic [PORT_CNT_BITS-1:0] BLOCKS_RESET = 5'd16;

  // Allocation policies.
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_mode_t;

  // Item classes decided by the front.
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_LOAD_BAD = 2'd1,
    OP_ALLOC    = 2'd2
  } op_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_t                  op;
    logic [IDX_BITS-1:0]  idx;
    logic [SIZE_BITS-1:0] size;
    logic                 last;
  } item_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

/* rtl/fpba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the block free-size table.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fpba_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and pushes them to the queue.
// Depends on fpba_pkg.
module fpba_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [fpba_pkg::PORT_IDX_BITS-1:0]   block_index,
  input  logic [fpba_pkg::PORT_SIZE_BITS-1:0]  size_value,
  input  logic                                 last_of_batch,
  input  logic                                 q_full,
  output logic                                 push,
  output fpba_pkg::item_t                      push_item
);

  logic            held;
  fpba_pkg::item_t item;
  fpba_pkg::item_t item_next;

  // Classify the incoming request.
  always_comb begin
    item_next.idx  = fpba_pkg::IDX_BITS'(block_index);
    item_next.size = fpba_pkg::SIZE_BITS'(size_value);
    item_next.last = last_of_batch;
    if (action) begin
      item_next.op = fpba_pkg::OP_ALLOC;
    end else if (32'(block_index) < fpba_pkg::MAX_BLOCKS) begin
      item_next.op = fpba_pkg::OP_LOAD;
    end else begin
      item_next.op = fpba_pkg::OP_LOAD_BAD;
    end
  end

  assign push      = held && !q_full;
  assign push_item = item;
  assign in_ready  = !held || !q_full;

  // Holding register between the input port and the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/fpba_queue.sv */
`timescale 1ns / 1ps
// Short FIFO of classified requests between front and back.
// Depends on fpba_pkg.
module fpba_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fpba_pkg::item_t       push_item,
  output logic                  full,
  input  logic                  pop,
  output fpba_pkg::qhead_t      head
);

  fpba_pkg::item_t                  slots [fpba_pkg::QUEUE_DEPTH];
  logic [fpba_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [fpba_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [fpba_pkg::QCNT_BITS-1:0]   fill;

  assign full       = fill == fpba_pkg::QCNT_BITS'(fpba_pkg::QUEUE_DEPTH);
  assign head.valid = fill != '0;
  assign head.item  = slots[rd_ptr];

  // Pointers wrap at the queue depth.
  function automatic logic [fpba_pkg::QPTR_BITS-1:0] ptr_inc(
    input logic [fpba_pkg::QPTR_BITS-1:0] p
  );
    if (32'(p) == fpba_pkg::QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Storage, pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/fpba_back.sv */
`timescale 1ns / 1ps
// Back end: carries out loads and allocations against the free-size table.
// Depends on fpba_pkg and fpba_ram.
module fpba_back (
  input  logic                              clk,
  input  logic                              rst,
  input  fpba_pkg::fit_mode_t               fit_mode,
  input  logic [fpba_pkg::CNT_BITS-1:0]     search_count,
  input  fpba_pkg::qhead_t                  head,
  output logic                              pop,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_granted,
  output logic [fpba_pkg::IDX_BITS-1:0]     res_block,
  output logic [fpba_pkg::SIZE_BITS-1:0]    res_size
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                           state;
  fpba_pkg::item_t                  cur;
  logic [fpba_pkg::IDX_BITS-1:0]    cur_j;
  logic [fpba_pkg::CNT_BITS-1:0]    scan_k;
  logic                             found;
  logic [fpba_pkg::IDX_BITS-1:0]    pick;
  logic [fpba_pkg::SIZE_BITS-1:0]   pick_val;
  logic [fpba_pkg::CNT_BITS-1:0]    next_fit_start;

  logic                             ram_we;
  logic [fpba_pkg::IDX_BITS-1:0]    ram_waddr;
  logic [fpba_pkg::SIZE_BITS-1:0]   ram_wdata;
  logic [fpba_pkg::IDX_BITS-1:0]    ram_raddr;
  logic [fpba_pkg::SIZE_BITS-1:0]   ram_rdata;

  logic [fpba_pkg::IDX_BITS-1:0]    start;
  logic [fpba_pkg::CNT_BITS-1:0]    j_inc;
  logic [fpba_pkg::IDX_BITS-1:0]    j_wrap;
  logic                             fits;
  logic                             take;
  logic                             stop_early;
  logic                             last_step;
  logic [fpba_pkg::SIZE_BITS-1:0]   remain;
  logic                             res_set;

  fpba_ram #(
    .WIDTH(fpba_pkg::SIZE_BITS),
    .DEPTH(fpba_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new request is taken only when the result register is free or draining.
  assign pop = (state == ST_IDLE) && head.valid && (!res_valid || res_ready);

  // Next fit starts at the rotating pointer when it lies inside the count.
  always_comb begin
    if (fit_mode == fpba_pkg::FIT_NEXT && next_fit_start < search_count) begin
      start = fpba_pkg::IDX_BITS'(next_fit_start);
    end else begin
      start = '0;
    end
  end

  // Scan address steps one block per cycle and wraps at the count.
  assign j_inc  = fpba_pkg::CNT_BITS'(cur_j) + 1'b1;
  assign j_wrap = (j_inc == search_count) ? '0 : fpba_pkg::IDX_BITS'(j_inc);

  // Compare the block just read against the request and the current pick.
  assign fits       = ram_rdata >= cur.size;
  assign take       = fits && (!found ||
                      (fit_mode == fpba_pkg::FIT_BEST  && ram_rdata < pick_val) ||
                      (fit_mode == fpba_pkg::FIT_WORST && ram_rdata > pick_val));
  assign stop_early = fits && (fit_mode == fpba_pkg::FIT_FIRST ||
                               fit_mode == fpba_pkg::FIT_NEXT);
  assign last_step  = scan_k == search_count - 1'b1;
  assign remain     = pick_val - cur.size;

  // A result is produced this cycle: an immediate answer on a taken load or
  // zero-count allocation, a failed scan, or the write-back of a granted allocation.
  assign res_set = (pop && !(head.item.op == fpba_pkg::OP_ALLOC && search_count != '0)) ||
                   (state == ST_SCAN && (stop_early || last_step) && !(found || fits)) ||
                   (state == ST_WRITE);

  // Table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head.item.idx;
    ram_wdata = head.item.size;
    ram_raddr = start;
    case (state)
      ST_IDLE: begin
        ram_we = pop && head.item.op == fpba_pkg::OP_LOAD;
      end
      ST_SCAN: begin
        ram_raddr = j_wrap;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pick;
        ram_wdata = remain;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, result register and next fit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      res_valid      <= 1'b0;
      found          <= 1'b0;
      next_fit_start <= '0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            cur <= head.item;
            case (head.item.op)
              fpba_pkg::OP_LOAD: begin
                res_granted <= 1'b1;
                res_block   <= head.item.idx;
                res_size    <= head.item.size;
                if (head.item.last) begin
                  next_fit_start <= '0;
                end
              end
              fpba_pkg::OP_ALLOC: begin
                if (search_count == '0) begin
                  res_granted <= 1'b0;
                  res_block   <= '0;
                  res_size    <= '0;
                  if (head.item.last) begin
                    next_fit_start <= '0;
                  end
                end else begin
                  state  <= ST_SCAN;
                  cur_j  <= start;
                  scan_k <= '0;
                  found  <= 1'b0;
                end
              end
              default: begin
                res_granted <= 1'b0;
                res_block   <= '0;
                res_size    <= '0;
                if (head.item.last) begin
                  next_fit_start <= '0;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (take) begin
            found    <= 1'b1;
            pick     <= cur_j;
            pick_val <= ram_rdata;
          end
          if (stop_early || last_step) begin
            if (found || fits) begin
              state <= ST_WRITE;
            end else begin
              state       <= ST_IDLE;
              res_granted <= 1'b0;
              res_block   <= '0;
              res_size    <= '0;
              if (cur.last) begin
                next_fit_start <= '0;
              end
            end
          end else begin
            cur_j  <= j_wrap;
            scan_k <= scan_k + 1'b1;
          end
        end
        ST_WRITE: begin
          state       <= ST_IDLE;
          res_granted <= 1'b1;
          res_block   <= pick;
          res_size    <= remain;
          if (cur.last) begin
            next_fit_start <= '0;
          end else if (fit_mode == fpba_pkg::FIT_NEXT) begin
            next_fit_start <= fpba_pkg::CNT_BITS'(pick) + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result is never written over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (!res_valid || res_ready))
    else $error("result register overwritten");

  // The scan never runs past the searched block count.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_k < search_count))
    else $error("scan ran past the block count");

  // Every write-back returns to idle with a granted result.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (state == ST_IDLE && res_valid && res_granted))
    else $error("write-back did not produce a grant");

  // The queue is only drained while idle.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && head.valid))
    else $error("request taken outside idle");
`endif

endmodule

/* rtl/fit_policy_block_allocator_core.sv */
`timescale 1ns / 1ps
// Top level of the fit-policy block allocator: configuration registers and
// the front, queue and back. Depends on fpba_pkg and all fpba_* modules.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transfer:
//   action 0 loads block_index with free size size_value, action 1 allocates
//   size_value bytes from a block chosen by fit_mode. last_of_batch clears
//   the next fit pointer once the request is done.
//   The output channel (out_valid/out_ready) returns exactly one result per
//   request: granted, chosen_block and remaining_size, in request order.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; index 0 sets fit_mode, index 1 sets blocks_in_use. Write it
//   only while no request is in flight.
//   A load, or an allocation while the block count is zero, is answered
//   directly when it is taken from the queue; any other allocation scans
//   up to blocks_in_use blocks, capped at 16, and a granted one then writes
//   back the chosen block. A request is taken from the queue only once the
//   one before it is done; the scan reads one table entry per cycle.
//   A stalled receiver holds the result; up to three further requests are
//   still accepted into the input register and queue before in_ready drops.
//   Reset clears the pointer and sets best fit over 16 blocks; the free-size
//   table holds no defined value until each block is loaded.
module fit_policy_block_allocator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [fpba_pkg::PORT_IDX_BITS-1:0]    block_index,
  input  logic [fpba_pkg::PORT_SIZE_BITS-1:0]   size_value,
  input  logic                                  last_of_batch,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  granted,
  output logic [fpba_pkg::PORT_IDX_BITS-1:0]    chosen_block,
  output logic [fpba_pkg::PORT_SIZE_BITS-1:0]   remaining_size,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fpba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fpba_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  fpba_pkg::fit_mode_t                  fit_mode;
  logic [fpba_pkg::PORT_CNT_BITS-1:0]   blocks_in_use;
  logic [fpba_pkg::CNT_BITS-1:0]        search_count;

  logic                                 q_full;
  logic                                 push;
  fpba_pkg::item_t                      push_item;
  logic                                 pop;
  fpba_pkg::qhead_t                     head;
  logic [fpba_pkg::IDX_BITS-1:0]        res_block;
  logic [fpba_pkg::SIZE_BITS-1:0]       res_size;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= fpba_pkg::FIT_BEST;
      blocks_in_use <= fpba_pkg::BLOCKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpba_pkg::CFG_FIT_MODE: begin
          fit_mode <= fpba_pkg::fit_mode_t'(cfg_data[1:0]);
        end
        fpba_pkg::CFG_BLOCKS_IN_USE: begin
          blocks_in_use <= cfg_data;
        end
        default: begin
          fit_mode <= fit_mode;
        end
      endcase
    end
  end

  // The searched count saturates at the table size.
  always_comb begin
    if (32'(blocks_in_use) > fpba_pkg::MAX_BLOCKS) begin
      search_count = fpba_pkg::CNT_BITS'(fpba_pkg::MAX_BLOCKS);
    end else begin
      search_count = fpba_pkg::CNT_BITS'(blocks_in_use);
    end
  end

  fpba_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .block_index   (block_index),
    .size_value    (size_value),
    .last_of_batch (last_of_batch),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  fpba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  fpba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fit_mode     (fit_mode),
    .search_count (search_count),
    .head         (head),
    .pop          (pop),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res_granted  (granted),
    .res_block    (res_block),
    .res_size     (res_size)
  );

  // Result fields at port widths.
  assign chosen_block   = fpba_pkg::PORT_IDX_BITS'(res_block);
  assign remaining_size = fpba_pkg::PORT_SIZE_BITS'(res_size);

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fit_policy_block_allocator_core: loads, allocations and
// register writes under every fit policy, with random idling on both channels.
// Depends on fpba_pkg and the allocator RTL; needs no files or arguments.
module tb_top;
  import fpba_pkg::*;

  localparam int          HOLD_CYCLES  = 150;
  localparam int          DRAIN_CYCLES = 25;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 75;
  localparam int          PRESSURE_PH  = 3;
  localparam logic [15:0] SIZE_MAX     = 16'hFFFF;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  // One allocator answer: grant flag, block and the free size left in it.
  typedef struct {
    bit        granted;
    bit [3:0]  block;
    bit [15:0] remain;
  } grant_t;

  // Tracks the block table, the next fit pointer and both registers, and
  // checks each answer against the oldest predicted one.
  class fit_scoreboard;
    bit [SIZE_BITS-1:0]     free_size [MAX_BLOCKS];
    bit [PORT_CNT_BITS-1:0] next_start;
    fit_mode_t              mode;
    bit [PORT_CNT_BITS-1:0] blocks_cfg;
    grant_t                 pending_grants[$];
    int                     errors;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      next_start = '0;
      mode       = FIT_BEST;
      blocks_cfg = BLOCKS_RESET;
      errors     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] data);
      if (index == CFG_FIT_MODE)
        mode = fit_mode_t'(data[1:0]);
      else if (index == CFG_BLOCKS_IN_USE)
        blocks_cfg = data;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Works out the answer to one accepted request and updates the table.
    function void note_request(bit act, bit [3:0] idx, bit [15:0] size, bit last);
      grant_t g;
      int     count;
      int     start;
      int     j;
      int     pick;
      bit     found;
      g     = '{0, 0, 0};
      found = 0;
      pick  = 0;
      if (act == 1'b0) begin
        free_size[idx] = size;
        g = '{1, idx, size};
      end else begin
        count = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : blocks_cfg;
        if (mode == FIT_NEXT) begin
          // Circular scan from the pointer, or from zero when it is past the count.
          start = (next_start < count) ? next_start : 0;
          for (int k = 0; k < count && !found; k++) begin
            j = start + k;
            if (j >= count) j -= count;
            if (free_size[j] >= size) begin
              found = 1;
              pick  = j;
            end
          end
        end else begin
          // Linear scan; ties keep the lowest index.
          for (int k = 0; k < count; k++) begin
            if (free_size[k] < size) continue;
            if (!found) begin
              found = 1;
              pick  = k;
              if (mode == FIT_FIRST) break;
            end else if (mode == FIT_BEST && free_size[k] < free_size[pick]) begin
              pick = k;
            end else if (mode == FIT_WORST && free_size[k] > free_size[pick]) begin
              pick = k;
            end
          end
        end
        if (found) begin
          free_size[pick] = free_size[pick] - size;
          if (mode == FIT_NEXT) next_start = PORT_CNT_BITS'(pick + 1);
          g = '{1, pick[3:0], free_size[pick]};
        end
      end
      if (last) next_start = '0;
      pending_grants.push_back(g);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    // Compares one answer with the oldest expectation, field by field.
    task check_result(bit got_grant, bit [3:0] got_block, bit [15:0] got_remain);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected answer granted=%0d block=%0d remain=%0d",
                                  got_grant, got_block, got_remain));
      end else begin
        exp_g = pending_grants.pop_front();
        if (got_grant !== exp_g.granted)
          report_mismatch($sformatf("granted got %0d want %0d", got_grant, exp_g.granted));
        if (got_block !== exp_g.block)
          report_mismatch($sformatf("chosen_block got %0d want %0d", got_block, exp_g.block));
        if (got_remain !== exp_g.remain)
          report_mismatch($sformatf("remaining_size got %0d want %0d",
                                    got_remain, exp_g.remain));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      action;
  logic [PORT_IDX_BITS-1:0]  block_index;
  logic [PORT_SIZE_BITS-1:0] size_value;
  logic                      last_of_batch;
  logic                      out_valid;
  logic                      out_ready;
  logic                      granted;
  logic [PORT_IDX_BITS-1:0]  chosen_block;
  logic [PORT_SIZE_BITS-1:0] remaining_size;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  fit_scoreboard sb = new();
  bit            idle_enabled = 1;
  bit            hold_output  = 0;
  int unsigned   stall_left   = 0;

  fit_policy_block_allocator_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .block_index    (block_index),
    .size_value     (size_value),
    .last_of_batch  (last_of_batch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .chosen_block   (chosen_block),
    .remaining_size (remaining_size),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("fit_policy_block_allocator_core regression: fail");
    $finish;
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sizes biased toward the extremes, with small requests so that grants are common.
  function automatic bit [15:0] pick_size(bit for_alloc);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return SIZE_MAX;
    if (for_alloc && r < 80) return 16'($urandom_range(0, 3000));
    if (!for_alloc && r < 70) return 16'($urandom_range(1000, 20000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offers one request and returns once it has been accepted.
  task automatic send_request(bit act, bit [3:0] idx, bit [15:0] size, bit last);
    @(negedge clk);
    in_valid      <= 1'b1;
    action        <= act;
    block_index   <= idx;
    size_value    <= size;
    last_of_batch <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, idx, size, last);
  endtask

  task automatic input_gap(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted answer has arrived, then lets the block settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_request();
    bit act;
    act = ($urandom_range(0, 99) < 70);
    send_request(act, 4'($urandom_range(0, 15)), pick_size(act),
                 $urandom_range(0, 99) < 15);
    input_gap(pick_gap());
  endtask

  // Receiver: random stalls, and a long forced hold-off when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Answer checking at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(granted, chosen_block, remaining_size);
  end

  // Main sequence.
  initial begin
    fit_mode_t                mode_sel;
    logic [CFG_DATA_BITS-1:0] count_sel;
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = 1'b0;
    block_index   = '0;
    size_value    = '0;
    last_of_batch = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_FIT_MODE;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: load every block so that no scan sees an unwritten entry.
    // Block 0 is full, block 15 empty, odd blocks tie at the same size.
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i == 0)
        send_request(1'b0, 4'(i), SIZE_MAX, 1'b0);
      else if (i == MAX_BLOCKS - 1)
        send_request(1'b0, 4'(i), '0, 1'b0);
      else
        send_request(1'b0, 4'(i), (i % 2) ? 16'd50 : 16'(400 + i), 1'b0);
    end
    // Zero request, a tie, the largest request twice (the second finds no room).
    send_request(1'b1, 4'd15, 16'd0, 1'b0);
    send_request(1'b1, 4'd0, 16'd40, 1'b0);
    send_request(1'b1, 4'd7, SIZE_MAX, 1'b0);
    send_request(1'b1, 4'd9, SIZE_MAX, 1'b1);
    send_request(1'b1, 4'd3, 16'd1, 1'b0);
    input_gap(1);
    wait_idle();

    // Random phases, each under its own policy and block count.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin mode_sel = FIT_FIRST; count_sel = 5'd16; end
        1:       begin mode_sel = FIT_NEXT;  count_sel = 5'd16; end
        2:       begin mode_sel = FIT_BEST;  count_sel = 5'd1;  end
        3:       begin mode_sel = FIT_WORST; count_sel = 5'd16; end
        4:       begin mode_sel = FIT_NEXT;  count_sel = 5'd5;  end
        5:       begin mode_sel = FIT_FIRST; count_sel = 5'd0;  end
        6:       begin mode_sel = FIT_NEXT;  count_sel = 5'd31; end
        7:       begin mode_sel = FIT_WORST; count_sel = 5'd2;  end
        default: begin
          mode_sel  = fit_mode_t'($urandom_range(0, 3));
          count_sel = CFG_DATA_BITS'($urandom_range(1, 16));
        end
      endcase
      write_register(CFG_FIT_MODE, CFG_DATA_BITS'(mode_sel));
      write_register(CFG_BLOCKS_IN_USE, count_sel);
      // The spare index takes no effect but toggles the upper index bit.
      if (p % 4 == 1) write_register(CFG_SPARE, CFG_DATA_BITS'($urandom_range(0, 31)));

      idle_enabled = (p % 4 != 2) && (p != PRESSURE_PH);
      if (p == PRESSURE_PH) hold_output = 1;
      repeat (PHASE_ITEMS) random_request();
      input_gap(1);
      wait_idle();
      idle_enabled = 1;
    end

    if (sb.errors == 0)
      $display("fit_policy_block_allocator_core regression: pass");
    else
      $display("fit_policy_block_allocator_core regression: fail");
    $finish;
  end

endmodule
